@@ rtl/esdba_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esdba_pkg
// Shared types and constants for the echo sample decode and bin average block.
// ----------------------------------------------------------------------------
package esdba_pkg;

    // Sample format: 4-bit exponent above a 12-bit mantissa
    localparam int unsigned RAW_W   = 16;
    localparam int unsigned MANT_W  = 12;
    localparam int unsigned EXP_LSB = 12;
    localparam int unsigned EXP_W   = 4;

    localparam int unsigned SUM_W   = 32;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned ROW_W   = 13;
    localparam int unsigned FACT_W  = 8;
    localparam int unsigned DIVS_W  = 2 * FACT_W;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_PING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_FACTOR      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FACTOR    = 2'd2;

    localparam logic [ROW_W-1:0]  SAMPLES_PER_PING_RST = 13'd4096;
    localparam logic [FACT_W-1:0] FACTOR_RST           = 8'd1;

    // Effective configuration (zero treated as one, row clamped)
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [FACT_W-1:0] pf;
        logic [FACT_W-1:0] sf;
    } cfg_eff_t;

    // Division request: block sum over block area, with its tags
    typedef struct packed {
        logic [SUM_W-1:0]  dividend;
        logic [DIVS_W-1:0] divisor;
        logic [TIME_W-1:0] mid_time;
        logic              row_end;
    } div_req_t;

    typedef struct packed {
        logic [SUM_W-1:0]  quotient;
        logic [TIME_W-1:0] mid_time;
        logic              row_end;
    } div_res_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

endpackage : esdba_pkg
`default_nettype wire

@@ rtl/esdba_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esdba_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module esdba_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  wire logic                                      aclk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic                                      re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register the read data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule : esdba_ram
`default_nettype wire

@@ rtl/esdba_accum.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esdba_accum
// Sample decode, stream position tracking and read-modify-write of bin sums.
// ----------------------------------------------------------------------------
module esdba_accum import esdba_pkg::*; #(
    parameter int unsigned MAX_SAMPLES = 4096
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_eff_t           cfg,
    input  wire logic               restart,
    input  wire logic               accept,
    input  wire logic [RAW_W-1:0]   raw_sample,
    input  wire logic [TIME_W-1:0]  ping_time,
    output logic                    would_emit,
    output logic                    emit_pending,
    output logic                    req_valid,
    output div_req_t                req
);

    localparam int unsigned ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    // Stream position
    logic [ROW_W-1:0]  sample_index_reg, sample_index_next;
    logic [FACT_W-1:0] offset_reg, offset_next;
    logic [FACT_W-1:0] ping_reg, ping_next;
    logic [ROW_W-1:0]  bin_start_reg, bin_start_next;
    logic [ROW_W-1:0]  bin_pos_reg, bin_pos_next;
    logic [SUM_W-1:0]  partial_reg, partial_next;
    logic [TIME_W-1:0] held_time_reg, held_time_next;

    // Second stage: bin completed, memory data arrives
    logic              s2_valid_reg, s2_valid_next;
    logic [SUM_W-1:0]  s2_sum_reg, s2_sum_next;
    logic [ADDR_W-1:0] s2_addr_reg, s2_addr_next;
    logic              s2_use_mem_reg, s2_use_mem_next;
    logic              s2_emit_reg, s2_emit_next;
    logic              s2_row_end_reg, s2_row_end_next;
    logic [TIME_W-1:0] s2_time_reg, s2_time_next;

    // Last write, for a read that raced it
    logic              fwd_valid_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    logic [SUM_W-1:0]  fwd_data_reg;

    logic [SUM_W-1:0]  value;
    logic [SUM_W-1:0]  sum;
    logic              whole;
    logic              bin_done;
    logic              group_done;
    logic              row_last;
    logic              last_bin;
    logic              mid_capture;
    logic [SUM_W-1:0]  rdata;
    logic [SUM_W-1:0]  mem_val;
    logic [SUM_W-1:0]  total;
    logic              mem_we;

    // Decode: mantissa shifted left by exponent
    assign value = {{(SUM_W-MANT_W){1'b0}}, raw_sample[MANT_W-1:0]}
                   << raw_sample[EXP_LSB +: EXP_W];
    assign sum   = partial_reg + value;

    // Position tests
    assign whole      = ({1'b0, bin_start_reg} + {6'd0, cfg.sf}) <= {1'b0, cfg.row};
    assign bin_done   = whole && (({1'b0, offset_reg} + 9'd1) >= {1'b0, cfg.sf});
    assign group_done = ({1'b0, ping_reg} + 9'd1) >= {1'b0, cfg.pf};
    assign row_last   = ({1'b0, sample_index_reg} + 14'd1) >= {1'b0, cfg.row};
    assign last_bin   = ({2'd0, bin_start_reg} + {7'd0, cfg.sf} + {7'd0, cfg.sf})
                        > {2'd0, cfg.row};
    assign mid_capture = (sample_index_reg == '0) && (ping_reg == {1'b0, cfg.pf[7:1]});

    assign would_emit   = bin_done && group_done;
    assign emit_pending = s2_valid_reg && s2_emit_reg;

    // Advance stream position on each accepted sample; a restart clears it
    always_comb begin
        sample_index_next = sample_index_reg;
        offset_next       = offset_reg;
        ping_next         = ping_reg;
        bin_start_next    = bin_start_reg;
        bin_pos_next      = bin_pos_reg;
        partial_next      = partial_reg;
        held_time_next    = held_time_reg;
        s2_valid_next     = 1'b0;
        s2_sum_next       = sum;
        s2_addr_next      = ADDR_W'(bin_pos_reg);
        s2_use_mem_next   = (ping_reg != '0);
        s2_emit_next      = group_done;
        s2_row_end_next   = last_bin;
        s2_time_next      = mid_capture ? ping_time : held_time_reg;
        if (restart) begin
            sample_index_next = '0;
            offset_next       = '0;
            ping_next         = '0;
            bin_start_next    = '0;
            bin_pos_next      = '0;
            partial_next      = '0;
        end else if (accept) begin
            if (mid_capture) begin
                held_time_next = ping_time;
            end
            if (whole) begin
                if (bin_done) begin
                    partial_next   = '0;
                    offset_next    = '0;
                    s2_valid_next  = 1'b1;
                    bin_pos_next   = bin_pos_reg + 13'd1;
                    bin_start_next = bin_start_reg + {5'd0, cfg.sf};
                end else begin
                    partial_next = sum;
                    offset_next  = offset_reg + 8'd1;
                end
            end
            if (row_last) begin
                sample_index_next = '0;
                offset_next       = '0;
                partial_next      = '0;
                bin_pos_next      = '0;
                bin_start_next    = '0;
                ping_next         = group_done ? '0 : ping_reg + 8'd1;
            end else begin
                sample_index_next = sample_index_reg + 13'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_index_reg <= '0;
            offset_reg       <= '0;
            ping_reg         <= '0;
            bin_start_reg    <= '0;
            bin_pos_reg      <= '0;
            partial_reg      <= '0;
            held_time_reg    <= '0;
            s2_valid_reg     <= 1'b0;
            fwd_valid_reg    <= 1'b0;
        end else begin
            sample_index_reg <= sample_index_next;
            offset_reg       <= offset_next;
            ping_reg         <= ping_next;
            bin_start_reg    <= bin_start_next;
            bin_pos_reg      <= bin_pos_next;
            partial_reg      <= partial_next;
            held_time_reg    <= held_time_next;
            s2_valid_reg     <= s2_valid_next;
            fwd_valid_reg    <= mem_we;
        end
    end

    always_ff @(posedge aclk) begin
        s2_sum_reg     <= s2_sum_next;
        s2_addr_reg    <= s2_addr_next;
        s2_use_mem_reg <= s2_use_mem_next;
        s2_emit_reg    <= s2_emit_next;
        s2_row_end_reg <= s2_row_end_next;
        s2_time_reg    <= s2_time_next;
        fwd_addr_reg   <= s2_addr_reg;
        fwd_data_reg   <= total;
    end

    // Combine with the stored sum; forward a write made in the previous cycle
    assign mem_val = (fwd_valid_reg && (fwd_addr_reg == s2_addr_reg)) ? fwd_data_reg
                                                                       : rdata;
    assign total   = s2_sum_reg + (s2_use_mem_reg ? mem_val : '0);
    assign mem_we  = s2_valid_reg && !s2_emit_reg;

    esdba_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_SAMPLES)
    ) u_bin_sums (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (s2_addr_reg),
        .wdata (total),
        .re    (accept),
        .raddr (ADDR_W'(bin_pos_reg)),
        .rdata (rdata)
    );

    // Hand the finished block to the divider
    assign req_valid    = emit_pending;
    assign req.dividend = total;
    assign req.divisor  = {{FACT_W{1'b0}}, cfg.pf} * {{FACT_W{1'b0}}, cfg.sf};
    assign req.mid_time = s2_time_reg;
    assign req.row_end  = s2_row_end_reg;

endmodule : esdba_accum
`default_nettype wire

@@ rtl/esdba_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esdba_div
// Restoring divider, one quotient bit per cycle, holds its result until taken.
// ----------------------------------------------------------------------------
module esdba_div import esdba_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     req_valid,
    input  wire div_req_t req,
    input  wire logic     res_ready,
    output logic          busy,
    output logic          res_valid,
    output div_res_t      res
);

    localparam int unsigned CNT_W = $clog2(SUM_W);

    div_state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [DIVS_W:0]   rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [DIVS_W-1:0] divisor_reg, divisor_next;
    logic [TIME_W-1:0] time_reg, time_next;
    logic              row_end_reg, row_end_next;

    logic [DIVS_W:0]   rem_shift;
    logic              fits;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE: if (req_valid) begin
                state_next = DIV_RUN;
            end
            DIV_RUN: if (count_reg == '0) begin
                state_next = DIV_DONE;
            end
            DIV_DONE: if (res_ready) begin
                state_next = DIV_IDLE;
            end
            default: state_next = DIV_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        busy      = 1'b1;
        res_valid = 1'b0;
        case (state_reg)
            DIV_IDLE: busy      = 1'b0;
            DIV_RUN:  busy      = 1'b1;
            DIV_DONE: res_valid = 1'b1;
            default:  busy      = 1'b0;
        endcase
    end

    // One shift-subtract step
    assign rem_shift = {rem_reg[DIVS_W-1:0], quo_reg[SUM_W-1]};
    assign fits      = rem_shift >= {1'b0, divisor_reg};

    always_comb begin
        count_next   = count_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        time_next    = time_reg;
        row_end_next = row_end_reg;
        if (state_reg == DIV_IDLE && req_valid) begin
            count_next   = CNT_W'(SUM_W - 1);
            rem_next     = '0;
            quo_next     = req.dividend;
            divisor_next = req.divisor;
            time_next    = req.mid_time;
            row_end_next = req.row_end;
        end else if (state_reg == DIV_RUN) begin
            count_next = count_reg - 1'b1;
            rem_next   = fits ? rem_shift - {1'b0, divisor_reg} : rem_shift;
            quo_next   = {quo_reg[SUM_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg   <= count_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
        time_reg    <= time_next;
        row_end_reg <= row_end_next;
    end

    assign res.quotient = quo_reg;
    assign res.mid_time = time_reg;
    assign res.row_end  = row_end_reg;

endmodule : esdba_div
`default_nettype wire

@@ rtl/echo_sample_decode_bin_average.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// echo_sample_decode_bin_average
// Decodes packed echo samples and averages them over ping-by-sample blocks.
// ----------------------------------------------------------------------------
// Input stream s_*: one packed sample per request, ping by ping, each with its
// ping time. Output stream m_*: one block average per completed block, with
// the middle ping's time; tlast marks the last bin of the output column.
// Configuration is written through cfg_wen/cfg_index/cfg_wdata while idle;
// each write to a known register restarts the stream position.
// Throughput: one sample per cycle, but a sample that completes a block waits
// while the divider still works on or holds the previous result. The radix-2
// divider takes 32 steps per result. From an accepted sample to m_tvalid a
// result passes the bin-sum memory read, the 32 divider steps and the output
// register. Bin sums live in a one-port-read memory with a registered read;
// a write racing the next read of the same bin is forwarded.
// Reset clears position, counters and output; configuration returns to 4096
// samples per ping and factors of one. The memory needs no clearing. When
// the receiver stalls, the result holds in the output register, the divider
// holds its next result, and input stalls once a further block would finish.
// ----------------------------------------------------------------------------
module echo_sample_decode_bin_average import esdba_pkg::*; #(
    parameter int unsigned MAX_SAMPLES = 4096
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Configuration write port
    input  wire logic                 cfg_wen,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ROW_W-1:0]     cfg_wdata,
    // Sample stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [47:0]          s_tdata,   // raw_sample[15:0], ping_time[47:16]
    // Result stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [63:0]               m_tdata,   // bin_average[31:0], middle_time[63:32]
    output logic                      m_tlast    // row_end
);

    localparam logic [16:0] MAX_ROW = 17'(MAX_SAMPLES);

    logic [ROW_W-1:0]  spp_reg, spp_next;
    logic [FACT_W-1:0] pf_reg, pf_next;
    logic [FACT_W-1:0] sf_reg, sf_next;
    logic              restart;

    cfg_eff_t cfg;
    logic     accept;
    logic     would_emit;
    logic     emit_pending;
    logic     req_valid;
    div_req_t req;
    logic     div_busy;
    logic     res_valid;
    div_res_t res;
    logic     out_ready;
    logic     out_load;

    logic              m_valid_reg, m_valid_next;
    logic [SUM_W-1:0]  m_avg_reg;
    logic [TIME_W-1:0] m_time_reg;
    logic              m_last_reg;

    // Configuration registers
    always_comb begin
        spp_next = spp_reg;
        pf_next  = pf_reg;
        sf_next  = sf_reg;
        restart  = 1'b0;
        if (cfg_wen) begin
            case (cfg_index)
                CFG_SAMPLES_PER_PING: begin
                    spp_next = cfg_wdata;
                    restart  = 1'b1;
                end
                CFG_PING_FACTOR: begin
                    pf_next = cfg_wdata[FACT_W-1:0];
                    restart = 1'b1;
                end
                CFG_SAMPLE_FACTOR: begin
                    sf_next = cfg_wdata[FACT_W-1:0];
                    restart = 1'b1;
                end
                default: restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spp_reg <= SAMPLES_PER_PING_RST;
            pf_reg  <= FACTOR_RST;
            sf_reg  <= FACTOR_RST;
        end else begin
            spp_reg <= spp_next;
            pf_reg  <= pf_next;
            sf_reg  <= sf_next;
        end
    end

    // Effective values: zero acts as one, row clamped to the memory depth
    always_comb begin
        cfg.row = spp_reg;
        if (spp_reg == '0) begin
            cfg.row = 13'd1;
        end else if ({4'd0, spp_reg} > MAX_ROW) begin
            cfg.row = ROW_W'(MAX_ROW);
        end
        cfg.pf = (pf_reg == '0) ? FACTOR_RST : pf_reg;
        cfg.sf = (sf_reg == '0) ? FACTOR_RST : sf_reg;
    end

    // Stall a block-completing request while the divider is taken
    assign s_tready = !(would_emit && (div_busy || emit_pending));
    assign accept   = s_tvalid && s_tready;

    esdba_accum #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_accum (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .restart      (restart),
        .accept       (accept),
        .raw_sample   (s_tdata[15:0]),
        .ping_time    (s_tdata[47:16]),
        .would_emit   (would_emit),
        .emit_pending (emit_pending),
        .req_valid    (req_valid),
        .req          (req)
    );

    esdba_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req       (req),
        .res_ready (out_ready),
        .busy      (div_busy),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register
    assign out_ready = !m_valid_reg || m_tready;
    assign out_load  = res_valid && out_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_avg_reg  <= res.quotient;
            m_time_reg <= res.mid_time;
            m_last_reg <= res.row_end;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_time_reg, m_avg_reg};
    assign m_tlast  = m_last_reg;

endmodule : echo_sample_decode_bin_average
`default_nettype wire

@@ rtl/esdba_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esdba_checker
// Port-level checks for the echo sample decode and bin average block.
// ----------------------------------------------------------------------------
module esdba_checker (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [63:0]          m_tdata,
    input wire logic                 m_tlast
);

    // Hold a stalled result
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed or dropped");

    // Leave reset empty and ready for samples
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    // A result needs a memory read and divider steps after reset
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(aresetn, 1) && $past(aresetn, 2) && $past(aresetn, 3))
        else $error("result too soon after reset");

    // Input stalls only while a result is still in flight
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready && $past(aresetn, 1) && $past(aresetn, 2)
            |-> $past(s_tvalid && s_tready, 1) || $past(!s_tready, 1))
        else $error("input stalled with nothing in flight");

endmodule : esdba_checker

bind echo_sample_decode_bin_average esdba_checker u_esdba_checker (.*);
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of echo_sample_decode_bin_average. Directed tests hit
// the decode corners, zero and oversized registers, sum wrap, short rows,
// dropped tail samples, unfinished groups and stream restarts. A random
// stream then runs over many block shapes. Every accepted sample goes
// through a local model of the decoder and block averager, and each result
// request is matched in order against the model's output.
// ----------------------------------------------------------------------------
module testbench;
    import esdba_pkg::*;

    localparam int unsigned ROW_MAX       = 4096;
    localparam int unsigned SETTLE_CYCLES = 40;      // covers the result latency
    localparam int unsigned RUN_LIMIT_NS  = 3000000;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [SUM_W-1:0]  avg;
        logic [TIME_W-1:0] mid;
        logic              last;
    } bin_result_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata   = '0;   // raw_sample[15:0], ping_time[47:16]
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [63:0]          m_tdata;          // bin_average[31:0], middle_time[63:32]
    logic                 m_tlast;          // row_end

    int unsigned send_idle_pct = 37;
    int unsigned recv_idle_pct = 72;
    int unsigned mismatch_count = 0;

    // Model of the averager: configuration, position and per-bin group sums
    logic [ROW_W-1:0]  cfg_row = SAMPLES_PER_PING_RST;
    logic [FACT_W-1:0] cfg_pf  = FACTOR_RST;
    logic [FACT_W-1:0] cfg_sf  = FACTOR_RST;
    logic [SUM_W-1:0]  column_sums [ROW_MAX];
    logic [SUM_W-1:0]  bin_acc = '0;
    logic [TIME_W-1:0] mid_time_hold = '0;
    int unsigned       samp_pos = 0;
    int unsigned       bin_fill = 0;
    int unsigned       group_ping = 0;
    int unsigned       bin_idx = 0;
    bin_result_t       expected_bins [$];

    echo_sample_decode_bin_average #(
        .MAX_SAMPLES(ROW_MAX)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Advance the model by one sample; queue the block average it completes
    function automatic void predict_bin(input logic [RAW_W-1:0] raw,
                                        input logic [TIME_W-1:0] ping_t);
        int unsigned row_len, pf, sf, nbins;
        logic [SUM_W-1:0] level, total;
        bin_result_t res;
        row_len = (cfg_row == 0) ? 1 : (cfg_row > ROW_MAX) ? ROW_MAX : cfg_row;
        pf = (cfg_pf == 0) ? 1 : cfg_pf;
        sf = (cfg_sf == 0) ? 1 : cfg_sf;
        nbins = row_len / sf;
        level = SUM_W'(raw[MANT_W-1:0]) << raw[EXP_LSB +: EXP_W];

        // Capture time on the first sample of the middle ping
        if (samp_pos == 0 && group_ping == pf / 2)
            mid_time_hold = ping_t;

        // Samples past the last whole bin are dropped
        if (samp_pos < nbins * sf) begin
            bin_acc += level;
            bin_fill++;
            if (bin_fill >= sf) begin
                total = bin_acc;
                if (group_ping != 0)
                    total += column_sums[bin_idx];
                bin_acc = '0;
                bin_fill = 0;
                if (group_ping + 1 >= pf) begin
                    res.avg  = total / SUM_W'(pf * sf);
                    res.mid  = mid_time_hold;
                    res.last = (bin_idx + 1 == nbins);
                    expected_bins.push_back(res);
                end else begin
                    column_sums[bin_idx] = total;
                end
                bin_idx++;
            end
        end

        // Wrap to the next ping row and ping group
        samp_pos++;
        if (samp_pos >= row_len) begin
            samp_pos = 0;
            bin_fill = 0;
            bin_acc = '0;
            bin_idx = 0;
            group_ping++;
            if (group_ping >= pf)
                group_ping = 0;
        end
    endfunction

    function automatic void flag_bin_error(input string why, input bin_result_t want,
                                           input bin_result_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s: expected avg=%h mid=%h end=%b, got avg=%h mid=%h end=%b",
                     $time, why, want.avg, want.mid, want.last,
                     got.avg, got.mid, got.last);
    endfunction

    // Result side: random back-pressure, compare each request with the oldest prediction
    always @(posedge aclk) begin : result_check
        bin_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.avg  = m_tdata[SUM_W-1:0];
            got.mid  = m_tdata[SUM_W +: TIME_W];
            got.last = m_tlast;
            if (expected_bins.size() == 0) begin
                flag_bin_error("result with nothing pending", '0, got);
            end else begin
                want = expected_bins.pop_front();
                if (got.avg !== want.avg || got.mid !== want.mid || got.last !== want.last)
                    flag_bin_error("result mismatch", want, got);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Present one sample, with a random gap first, and hold it until accepted
    task automatic send_sample(input logic [RAW_W-1:0] raw, input logic [TIME_W-1:0] ping_t);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ping_t, raw};
        do @(posedge aclk); while (!s_tready);
        predict_bin(raw, ping_t);
    endtask

    // Drop valid, drain every pending result, then let the pipeline go quiet
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (expected_bins.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            CFG_SAMPLES_PER_PING: cfg_row = val;
            CFG_PING_FACTOR:      cfg_pf  = val[FACT_W-1:0];
            CFG_SAMPLE_FACTOR:    cfg_sf  = val[FACT_W-1:0];
            default: ;
        endcase
        // Known registers restart the stream position; sums and held time stay
        if (idx inside {CFG_SAMPLES_PER_PING, CFG_PING_FACTOR, CFG_SAMPLE_FACTOR}) begin
            bin_acc = '0;
            samp_pos = 0;
            bin_fill = 0;
            group_ping = 0;
            bin_idx = 0;
        end
        @(posedge aclk);
    endtask

    // Factor writes carry random junk above the 8-bit field
    task automatic program_block(input int unsigned row_v, input int unsigned pf_v,
                                 input int unsigned sf_v);
        write_reg(CFG_SAMPLES_PER_PING, ROW_W'(row_v));
        write_reg(CFG_PING_FACTOR, ROW_W'(($urandom_range(0, 31) << FACT_W) | pf_v));
        write_reg(CFG_SAMPLE_FACTOR, ROW_W'(($urandom_range(0, 31) << FACT_W) | sf_v));
    endtask

    // Reset configuration: every sample is its own block; walk the decode corners
    task automatic test_reset_defaults();
        logic [RAW_W-1:0] corners [6];
        corners = '{16'h0000, 16'hFFFF, 16'h5AAA, 16'hA555, 16'h1FFF, 16'hF001};
        foreach (corners[i])
            send_sample(corners[i], i[0] ? '1 : '0);
        settle_block();
    endtask

    // Zero in every register acts as one
    task automatic test_zero_registers();
        program_block(0, 0, 0);
        repeat (2) send_sample(RAW_W'($urandom), $urandom);
        settle_block();
    endtask

    // Three full-scale samples, summed in one bin, stay within the 32-bit sum
    task automatic test_sum_wrap();
        program_block(3, 1, 3);
        repeat (3) send_sample(16'hFFFF, $urandom);
        settle_block();
    endtask

    // Bin wider than the row: nothing comes out
    task automatic test_short_row();
        program_block(2, 1, 3);
        repeat (2) send_sample(RAW_W'($urandom), $urandom);
        settle_block();
    endtask

    // Odd row drops its tail sample; a third ping starts a group that never closes
    task automatic test_tail_and_trailing();
        logic [TIME_W-1:0] ping_t;
        program_block(3, 2, 2);
        repeat (3) begin
            ping_t = $urandom;
            for (int k = 0; k < 3; k++)
                send_sample(RAW_W'($urandom), ping_t + k);   // only the first time counts
        end
        settle_block();
    endtask

    // Unused register index leaves the position alone; a real write restarts it
    task automatic test_restart();
        program_block(4, 1, 2);
        repeat (3) send_sample(RAW_W'($urandom), $urandom);
        settle_block();
        write_reg(CFG_UNUSED, ROW_W'($urandom));
        repeat (2) send_sample(RAW_W'($urandom), $urandom);
        settle_block();
        write_reg(CFG_SAMPLE_FACTOR, ROW_W'(2));
        repeat (4) send_sample(RAW_W'($urandom), $urandom);
        settle_block();
    endtask

    // Oversized row with the widest bins; deepest group
    task automatic test_largest_sizes();
        logic [TIME_W-1:0] ping_t;
        program_block(13'h1FFF, 1, 255);
        ping_t = $urandom;
        repeat (2 * 255) send_sample(RAW_W'($urandom), ping_t);
        settle_block();
        program_block(1, 255, 1);
        repeat (255) send_sample(16'hFFFF, $urandom);
        settle_block();
    endtask

    // Random block shapes, mostly whole groups, with some partial groups and noisy times
    task automatic test_random_stream(input int unsigned send_pct, input int unsigned recv_pct,
                                      input int unsigned quota);
        int unsigned sent, pick, row_v, pf_v, sf_v, row_e, pf_e, n;
        logic [TIME_W-1:0] ping_t;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < quota) begin
            pick  = $urandom_range(99);
            row_v = (pick < 8) ? 0 : (pick < 80) ? $urandom_range(1, 12) : $urandom_range(13, 40);
            pick  = $urandom_range(99);
            pf_v  = (pick < 8) ? 0 : (pick < 85) ? $urandom_range(1, 5) : $urandom_range(6, 16);
            pick  = $urandom_range(99);
            sf_v  = (pick < 8) ? 0 : (pick < 85) ? $urandom_range(1, 4) : $urandom_range(5, 12);
            program_block(row_v, pf_v, sf_v);
            row_e = (row_v == 0) ? 1 : row_v;
            pf_e  = (pf_v == 0) ? 1 : pf_v;
            n = $urandom_range(1, 3) * row_e * pf_e;
            if (n > 200)
                n = 200;
            if ($urandom_range(99) < 20)
                n += $urandom_range(1, row_e);
            for (int k = 0; k < n; k++) begin
                if (k % row_e == 0)
                    ping_t = $urandom;
                send_sample(RAW_W'($urandom), ($urandom_range(99) < 10) ? $urandom : ping_t);
            end
            sent += n;
            settle_block();
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_zero_registers();
        test_sum_wrap();
        test_short_row();
        test_tail_and_trailing();
        test_restart();
        test_largest_sizes();
        test_random_stream(37, 72, 218);
        test_random_stream(72, 37, 218);
        test_random_stream(0, 0, 218);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_bins.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/esdba_pkg.sv
rtl/esdba_ram.sv
rtl/esdba_accum.sv
rtl/esdba_div.sv
rtl/echo_sample_decode_bin_average.sv
rtl/esdba_checker.sv
sim/testbench.sv
